### design/ftcs_diffusion_stencil_step_core_defines.svh
// Assertion macros for the diffusion stencil core
`ifndef FTCS_DIFFUSION_STENCIL_STEP_CORE_DEFINES_SVH
`define FTCS_DIFFUSION_STENCIL_STEP_CORE_DEFINES_SVH

// condition holds on every clock edge out of reset
`define FDSS_ASSERT_HOLD(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fdss: invariant violated");

// condition on the same edge implies a consequence
`define FDSS_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("fdss: implication violated");

`endif

### design/fdss_pkg.sv
package fdss_pkg;

    localparam int MAX_COLS_DEF = 512;
    localparam int ROW_LIMIT    = 4096;

    localparam int CELL_W    = 32;
    localparam int GAIN_W    = 15;
    localparam int COLS_W    = 10;
    localparam int ROWS_W    = 13;
    localparam int ROW_CNT_W = 12;

    localparam int LAP_W  = 35;
    localparam int PROD_W = LAP_W + GAIN_W + 1;
    localparam int FRAC_W = 16;
    localparam int TERM_W = PROD_W - FRAC_W;
    localparam int SUM_W  = TERM_W + 1;

    localparam int APB_DW  = 32;
    localparam int PADDR_W = 4;

    localparam int OFIFO_DEPTH = 8;

    localparam logic [1:0] REG_GAIN = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_ROWS = 2'd2;

    localparam logic OP_CELL  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(6554);
    localparam logic [COLS_W-1:0] COLS_RST = COLS_W'(512);
    localparam logic [ROWS_W-1:0] ROWS_RST = ROWS_W'(512);

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

    localparam logic signed [CELL_W-1:0] CELL_MAX = {1'b0, {(CELL_W-1){1'b1}}};
    localparam logic signed [CELL_W-1:0] CELL_MIN = {1'b1, {(CELL_W-1){1'b0}}};

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [COLS_W-1:0] cols;
        logic [ROWS_W-1:0] rows;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic emit;
        logic drain;
        logic border;
        logic last;
    } t_s1_ctl;

    typedef struct packed {
        logic [CELL_W-1:0] cell_out;
        logic              frame_last;
    } t_result;

endpackage

### design/fdss_in_if.sv
interface fdss_in_if;
    import fdss_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic signed [CELL_W-1:0] cell_in;

    modport source (output valid, output opcode, output cell_in, input ready);
    modport sink   (input valid, input opcode, input cell_in, output ready);
endinterface

### design/fdss_out_if.sv
interface fdss_out_if;
    import fdss_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [CELL_W-1:0] cell_out;
    logic                     frame_last;

    modport source (output valid, output cell_out, output frame_last, input ready);
    modport sink   (input valid, input cell_out, input frame_last, output ready);
endinterface

### design/fdss_ram.sv
module fdss_ram #(
    parameter int WIDTH = 2 * fdss_pkg::CELL_W,
    parameter int DEPTH = fdss_pkg::MAX_COLS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

### design/fdss_cfg.sv
module fdss_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [1:0]                  i_reg_idx,
    input  logic [fdss_pkg::APB_DW-1:0] i_pwdata,
    output logic [fdss_pkg::APB_DW-1:0] o_prdata,
    output fdss_pkg::t_cfg              o_cfg
);
    import fdss_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign w_wr = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain <= GAIN_RST;
            r_cfg.cols <= COLS_RST;
            r_cfg.rows <= ROWS_RST;
        end else if (w_wr) begin
            unique case (i_reg_idx)
                REG_GAIN: r_cfg.gain <= i_pwdata[GAIN_W-1:0];
                REG_COLS: r_cfg.cols <= i_pwdata[COLS_W-1:0];
                REG_ROWS: r_cfg.rows <= i_pwdata[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_reg_idx)
            REG_GAIN: o_prdata = APB_DW'(r_cfg.gain);
            REG_COLS: o_prdata = APB_DW'(r_cfg.cols);
            REG_ROWS: o_prdata = APB_DW'(r_cfg.rows);
            default:  o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

### design/fdss_seq.sv
module fdss_seq #(
    parameter int MAX_COLS = fdss_pkg::MAX_COLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fdss_pkg::t_cfg              i_cfg,
    input  logic                        i_accept,
    input  logic                        i_opcode,
    input  logic [fdss_pkg::CELL_W-1:0] i_cell,
    output logic [$clog2(MAX_COLS)-1:0] o_raddr_a,
    output logic [$clog2(MAX_COLS)-1:0] o_raddr_b,
    output fdss_pkg::t_s1_ctl           o_ctl,
    output logic [$clog2(MAX_COLS)-1:0] o_col,
    output logic [fdss_pkg::CELL_W-1:0] o_cell
);
    import fdss_pkg::*;

    localparam int AW = $clog2(MAX_COLS);
    localparam int CW = $clog2(MAX_COLS + 1);

    logic [AW-1:0]        r_col, n_col;
    logic [ROW_CNT_W-1:0] r_row, n_row;
    logic [CW-1:0]        r_drains, n_drains;
    t_s1_ctl              r_ctl, n_ctl;
    logic [AW-1:0]        r_s1_col;
    logic [CELL_W-1:0]    r_s1_cell;

    logic [CW-1:0]        w_cols_eff;
    logic [ROWS_W-1:0]    w_rows_eff;
    logic                 w_restart;
    logic [AW-1:0]        w_col;
    logic [ROW_CNT_W-1:0] w_row;
    logic                 w_col_last;
    logic                 w_row_last;
    logic                 w_border;

    always_comb begin
        if (i_cfg.cols < COLS_W'(3)) begin
            w_cols_eff = CW'(3);
        end else if (32'(i_cfg.cols) > MAX_COLS) begin
            w_cols_eff = CW'(MAX_COLS);
        end else begin
            w_cols_eff = CW'(i_cfg.cols);
        end
        if (i_cfg.rows < ROWS_W'(3)) begin
            w_rows_eff = ROWS_W'(3);
        end else if (i_cfg.rows > ROWS_W'(ROW_LIMIT)) begin
            w_rows_eff = ROWS_W'(ROW_LIMIT);
        end else begin
            w_rows_eff = i_cfg.rows;
        end
    end

    assign w_restart  = (i_opcode == OP_CELL) && (r_drains != '0);
    assign w_col      = w_restart ? '0 : r_col;
    assign w_row      = w_restart ? '0 : r_row;
    assign w_col_last = 32'(w_col) >= (32'(w_cols_eff) - 32'd1);
    assign w_row_last = {1'b0, w_row} >= (w_rows_eff - ROWS_W'(1));
    assign w_border   = (w_col == '0) || w_col_last || (w_row == ROW_CNT_W'(1)) ||
                        ({1'b0, w_row} >= w_rows_eff);

    assign o_raddr_a = w_col;
    assign o_raddr_b = (w_col == AW'(MAX_COLS - 1)) ? '0 : w_col + AW'(1);

    always_comb begin
        n_ctl    = '0;
        n_col    = r_col;
        n_row    = r_row;
        n_drains = r_drains;
        if (i_accept) begin
            if (i_opcode == OP_DRAIN) begin
                if (r_drains != '0) begin
                    n_ctl.valid = 1'b1;
                    n_ctl.emit  = 1'b1;
                    n_ctl.drain = 1'b1;
                    n_ctl.last  = (r_drains == CW'(1));
                    n_drains    = r_drains - CW'(1);
                    n_col       = n_ctl.last ? '0 : r_col + AW'(1);
                end
            end else begin
                n_ctl.valid  = 1'b1;
                n_ctl.emit   = (w_row != '0);
                n_ctl.border = w_border;
                n_drains     = '0;
                if (w_col_last) begin
                    n_col = '0;
                    if (w_row_last) begin
                        n_row    = '0;
                        n_drains = w_cols_eff;
                    end else begin
                        n_row = w_row + ROW_CNT_W'(1);
                    end
                end else begin
                    n_col = w_col + AW'(1);
                    n_row = w_row;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_drains <= '0;
            r_ctl    <= '0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_drains <= n_drains;
            r_ctl    <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_col  <= w_col;
        r_s1_cell <= i_cell;
    end

    assign o_ctl  = r_ctl;
    assign o_col  = r_s1_col;
    assign o_cell = r_s1_cell;
endmodule

### design/fdss_alu.sv
module fdss_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fdss_pkg::t_s1_ctl             i_ctl,
    input  logic [fdss_pkg::CELL_W-1:0]   i_cell,
    input  logic [2*fdss_pkg::CELL_W-1:0] i_rdata_a,
    input  logic [fdss_pkg::CELL_W-1:0]   i_right,
    input  logic [fdss_pkg::GAIN_W-1:0]   i_gain,
    output logic                          o_push,
    output fdss_pkg::t_result             o_result,
    output logic [1:0]                    o_held
);
    import fdss_pkg::*;

    typedef struct packed {
        logic valid;
        logic pass;
        logic last;
    } t_stage;

    logic signed [CELL_W-1:0] w_up, w_down, w_left, w_right, w_centre;
    logic signed [LAP_W-1:0]  w_lap;
    logic signed [GAIN_W:0]   w_gain_s;
    logic signed [PROD_W-1:0] w_prod;
    logic        [PROD_W-1:0] w_round;
    logic signed [TERM_W-1:0] w_term;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [CELL_W-1:0] w_sat;

    t_stage                   r_s2, r_s3;
    logic signed [LAP_W-1:0]  r_s2_lap;
    logic signed [CELL_W-1:0] r_s2_centre, r_s3_centre, r_prev_centre;
    logic signed [PROD_W-1:0] r_s3_prod;

    assign w_centre = i_rdata_a[CELL_W-1:0];
    assign w_up     = i_rdata_a[2*CELL_W-1:CELL_W];
    assign w_right  = i_right;
    assign w_down   = i_cell;
    assign w_left   = r_prev_centre;

    assign w_lap = LAP_W'(w_up) + LAP_W'(w_down) + LAP_W'(w_left) + LAP_W'(w_right) -
                   (LAP_W'(w_centre) <<< 2);

    assign w_gain_s = $signed({1'b0, i_gain});
    assign w_prod   = r_s2_lap * w_gain_s;

    assign w_round = r_s3_prod + ROUND_HALF;
    assign w_term  = w_round[PROD_W-1:FRAC_W];
    assign w_sum   = SUM_W'(w_term) + SUM_W'(r_s3_centre);

    always_comb begin
        if ((&w_sum[SUM_W-1:CELL_W-1]) || !(|w_sum[SUM_W-1:CELL_W-1])) begin
            w_sat = w_sum[CELL_W-1:0];
        end else if (w_sum[SUM_W-1]) begin
            w_sat = CELL_MIN;
        end else begin
            w_sat = CELL_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_s2.valid <= i_ctl.emit;
            r_s2.pass  <= i_ctl.border || i_ctl.drain;
            r_s2.last  <= i_ctl.last;
            r_s3       <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_lap    <= w_lap;
        r_s2_centre <= w_centre;
        r_s3_prod   <= w_prod;
        r_s3_centre <= r_s2_centre;
        if (i_ctl.valid && !i_ctl.drain) begin
            r_prev_centre <= w_centre;
        end
    end

    assign o_push              = r_s3.valid;
    assign o_result.cell_out   = r_s3.pass ? r_s3_centre : w_sat;
    assign o_result.frame_last = r_s3.last;
    assign o_held              = 2'(r_s2.valid) + 2'(r_s3.valid);
endmodule

### design/fdss_ofifo.sv
module fdss_ofifo #(
    parameter int DEPTH = fdss_pkg::OFIFO_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  fdss_pkg::t_result          i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output fdss_pkg::t_result          o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import fdss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result       r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;
endmodule

### design/ftcs_diffusion_stencil_step_core.sv
// Five-point diffusion stencil, one explicit time step over a raster-order grid.
// Throughput: one word per cycle in and out unless stalled; one RAM write per cycle.
// A result passes the sequencer register, ALU stages s2 and s3 and the output queue,
// one grid row behind the input; the 8-word output queue absorbs stalls downstream.
// Reset (synchronous, active low) clears counters, pipeline and queue, sets the
// registers to their defaults; the row RAM is not cleared and is refilled by row 0.
`include "ftcs_diffusion_stencil_step_core_defines.svh"
module ftcs_diffusion_stencil_step_core #(
    parameter int MAX_COLS = fdss_pkg::MAX_COLS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fdss_in_if.sink                      i_in,
    fdss_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fdss_pkg::PADDR_W-1:0] paddr,
    input  logic [fdss_pkg::APB_DW-1:0]  pwdata,
    output logic [fdss_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import fdss_pkg::*;

    localparam int AW     = $clog2(MAX_COLS);
    localparam int CNT_W  = $clog2(OFIFO_DEPTH + 1);
    localparam int FILL_W = $clog2(OFIFO_DEPTH + 4);

    t_cfg                w_cfg;
    logic                w_in_acc;
    logic [AW-1:0]       w_raddr_a, w_raddr_b;
    logic [2*CELL_W-1:0] w_rdata_a, w_rdata_b;
    t_s1_ctl             w_s1_ctl;
    logic [AW-1:0]       w_s1_col;
    logic [CELL_W-1:0]   w_s1_cell;
    logic                w_we;
    logic [2*CELL_W-1:0] w_wdata;
    logic                w_push;
    t_result             w_result;
    logic [1:0]          w_held;
    logic [1:0]          w_inflight;
    logic [CNT_W-1:0]    w_fifo_cnt;
    logic [FILL_W-1:0]   w_load;
    logic                w_pop;
    logic                w_head_valid;
    t_result             w_head;

    assign pready = 1'b1;

    fdss_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_reg_idx (paddr[PADDR_W-1:2]),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    assign w_in_acc = i_in.valid && i_in.ready;

    fdss_seq #(
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_accept  (w_in_acc),
        .i_opcode  (i_in.opcode),
        .i_cell    (i_in.cell_in),
        .o_raddr_a (w_raddr_a),
        .o_raddr_b (w_raddr_b),
        .o_ctl     (w_s1_ctl),
        .o_col     (w_s1_col),
        .o_cell    (w_s1_cell)
    );

    assign w_we    = w_s1_ctl.valid && !w_s1_ctl.drain;
    assign w_wdata = {w_rdata_a[CELL_W-1:0], w_s1_cell};

    fdss_ram #(
        .WIDTH (2 * CELL_W),
        .DEPTH (MAX_COLS)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_s1_col),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    fdss_alu u_alu (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_s1_ctl),
        .i_cell    (w_s1_cell),
        .i_rdata_a (w_rdata_a),
        .i_right   (w_rdata_b[CELL_W-1:0]),
        .i_gain    (w_cfg.gain),
        .o_push    (w_push),
        .o_result  (w_result),
        .o_held    (w_held)
    );

    assign w_inflight = 2'(w_s1_ctl.emit) + w_held;
    assign w_load     = FILL_W'(w_fifo_cnt) + FILL_W'(w_inflight);
    assign i_in.ready = w_load < FILL_W'(OFIFO_DEPTH);

    assign w_pop = w_head_valid && o_out.ready;

    fdss_ofifo #(
        .DEPTH (OFIFO_DEPTH)
    ) u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_data  (w_head),
        .o_count (w_fifo_cnt)
    );

    assign o_out.valid      = w_head_valid;
    assign o_out.cell_out   = w_head.cell_out;
    assign o_out.frame_last = w_head.frame_last;

    `FDSS_ASSERT_HOLD(a_fill_bound, i_clk, i_rst_n, w_load <= FILL_W'(OFIFO_DEPTH))
    `FDSS_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, w_push, (w_fifo_cnt != CNT_W'(OFIFO_DEPTH)) || w_pop)
    `FDSS_ASSERT_IMPLY(a_no_ram_clash, i_clk, i_rst_n, w_we && w_in_acc, (w_s1_col != w_raddr_a) && (w_s1_col != w_raddr_b))
endmodule
